// ===== rtl/mel_pkg.sv =====
// Package with the shared types and constants of the mesh edge list builder.
package mel_pkg;

  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int VtxW        = 10;
  localparam int TriW        = 11;
  localparam int EdgeW       = 12;
  localparam int CntW        = 13;
  localparam int SweepW      = $clog2(MaxVertices);

  localparam logic [CntW-1:0] LinkNull = {CntW{1'b1}};
  localparam logic [CntW-1:0] CountMax = CntW'(MaxEdges);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_PASS1 = 2'd1,
    OP_PASS2 = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StMiss = 2'd2;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_DISPATCH, S_RD_WAIT, S_EDGE,
    S_PR_HEAD, S_PR_HWAIT, S_PR_CHK, S_PR_EWAIT,
    S_AP_START, S_AP_HWAIT, S_AP_WALK, S_AP_LWAIT, S_RESULT
  } bk_state_e;

  // One decoded item, with the three triangle edges as (start, end) pairs.
  typedef struct packed {
    op_e                       op;
    logic [2:0]                act;
    logic [2:0][VtxW-1:0]      es;
    logic [2:0][VtxW-1:0]      ee;
    logic [TriW-1:0]           tri_no;
    logic [EdgeW-1:0]          idx;
  } cmd_t;

  typedef struct packed {
    logic [VtxW-1:0] vtx_s;
    logic [VtxW-1:0] vtx_e;
    logic [TriW-1:0] tri_a;
    logic [TriW-1:0] tri_b;
  } edge_t;

  typedef struct packed {
    edge_t           edge_rec;
    logic [CntW-1:0] total;
    logic [1:0]      status;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } bk_stat_t;

endpackage

// ===== rtl/mel_front.sv =====
// Front part: decodes incoming items and queues them for the back part.
module mel_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [1:0]            operation_i,
  input  logic [9:0]            corner_zero_i,
  input  logic [9:0]            corner_one_i,
  input  logic [9:0]            corner_two_i,
  input  logic [10:0]           triangle_number_i,
  input  logic [11:0]           edge_number_i,
  input  mel_pkg::bk_stat_t     stat_i,
  output logic                  cmd_valid_o,
  output mel_pkg::cmd_t         cmd_o,
  input  logic                  cmd_pop_i
);
  import mel_pkg::*;

  cmd_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  cmd_t       dec;
  logic       do_push, do_pop;

  // Edge k runs from the previous corner to corner k.
  always_comb begin
    dec.op     = op_e'(operation_i);
    dec.tri_no = triangle_number_i;
    dec.idx    = edge_number_i;
    dec.es[0]  = corner_two_i;
    dec.ee[0]  = corner_zero_i;
    dec.es[1]  = corner_zero_i;
    dec.ee[1]  = corner_one_i;
    dec.es[2]  = corner_one_i;
    dec.ee[2]  = corner_two_i;
    for (int k = 0; k < 3; k++) begin
      case (dec.op)
        OP_PASS1: dec.act[k] = dec.es[k] < dec.ee[k];
        OP_PASS2: dec.act[k] = dec.es[k] > dec.ee[k];
        default:  dec.act[k] = 1'b0;
      endcase
    end
  end

  assign full_o      = (cnt_q == 2'd2) || stat_i.init_busy;
  assign do_push     = push_i && !full_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_mem[rd_q];

  // Two-entry command queue.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/mel_back.sv =====
// Back part: walks the edge lists in memory and builds one result per item.
module mel_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  mel_pkg::cmd_t     cmd_i,
  output logic              cmd_pop_o,
  output mel_pkg::bk_stat_t stat_o,
  output logic              res_push_o,
  output mel_pkg::res_t     res_o,
  input  logic              res_full_i
);
  import mel_pkg::*;

  logic [CntW-1:0] head_mem [MaxVertices];
  logic [CntW-1:0] link_mem [MaxEdges];
  edge_t           edge_mem [MaxEdges];

  bk_state_e         state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [1:0]        k_q, k_d;
  logic [EdgeW-1:0]  cur_q, cur_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [SweepW-1:0] sweep_q, sweep_d;
  logic              clr_q, clr_d;
  logic [1:0]        status_q, status_d;
  edge_t             rd_edge_q, rd_edge_d;

  logic [CntW-1:0]   head_rd_q, link_rd_q;
  edge_t             edge_rd_q;
  logic [SweepW-1:0] head_ra, head_wa;
  logic [EdgeW-1:0]  edge_ra, edge_wa, link_wa;
  logic [CntW-1:0]   head_wd, link_wd;
  edge_t             edge_wd;
  logic              head_we, edge_we, link_we;
  logic [VtxW-1:0]   es_k, ee_k;

  assign es_k = cmd_q.es[k_q];
  assign ee_k = cmd_q.ee[k_q];

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    edge_rd_q <= edge_mem[edge_ra];
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      count_q <= '0;
      sweep_q <= '0;
      clr_q   <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sweep_q <= sweep_d;
      clr_q   <= clr_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    cur_q     <= cur_d;
    status_q  <= status_d;
    rd_edge_q <= rd_edge_d;
  end

  // Next state, memory ports and result.
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    k_d        = k_q;
    cur_d      = cur_q;
    count_d    = count_q;
    sweep_d    = sweep_q;
    clr_d      = clr_q;
    status_d   = status_q;
    rd_edge_d  = rd_edge_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    head_ra    = es_k;
    head_we    = 1'b0;
    head_wa    = es_k;
    head_wd    = count_q;
    edge_ra    = cur_q;
    edge_we    = 1'b0;
    edge_wa    = count_q[EdgeW-1:0];
    edge_wd    = '{vtx_s: es_k, vtx_e: ee_k, tri_a: cmd_q.tri_no, tri_b: cmd_q.tri_no};
    link_we    = 1'b0;
    link_wa    = count_q[EdgeW-1:0];
    link_wd    = LinkNull;
    unique case (state_q)
      S_SWEEP: begin
        head_we = 1'b1;
        head_wa = sweep_q;
        head_wd = LinkNull;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == SweepW'(MaxVertices - 1)) begin
          state_d = clr_q ? S_RESULT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          status_d  = StOk;
          rd_edge_d = '0;
          k_d       = '0;
          state_d   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        edge_ra = cmd_q.idx;
        unique case (cmd_q.op)
          OP_CLEAR: begin
            count_d = '0;
            sweep_d = '0;
            clr_d   = 1'b1;
            state_d = S_SWEEP;
          end
          OP_READ: begin
            if ({1'b0, cmd_q.idx} < count_q) begin
              state_d = S_RD_WAIT;
            end else begin
              status_d = StMiss;
              state_d  = S_RESULT;
            end
          end
          default: state_d = S_EDGE;
        endcase
      end
      S_RD_WAIT: begin
        rd_edge_d = edge_rd_q;
        state_d   = S_RESULT;
      end
      S_EDGE: begin
        if (k_q == 2'd3) begin
          state_d = S_RESULT;
        end else if (!cmd_q.act[k_q]) begin
          k_d = k_q + 2'd1;
        end else if (cmd_q.op == OP_PASS2) begin
          state_d = S_PR_HEAD;
        end else begin
          state_d = S_AP_START;
        end
      end
      // Pairing walks the list of the lower vertex.
      S_PR_HEAD: begin
        head_ra = ee_k;
        state_d = S_PR_HWAIT;
      end
      S_PR_HWAIT: begin
        if (head_rd_q == LinkNull) begin
          state_d = S_AP_START;
        end else begin
          cur_d   = head_rd_q[EdgeW-1:0];
          state_d = S_PR_CHK;
        end
      end
      S_PR_CHK: begin
        state_d = S_PR_EWAIT;
      end
      S_PR_EWAIT: begin
        if (edge_rd_q.vtx_e == es_k && edge_rd_q.tri_a == edge_rd_q.tri_b) begin
          edge_we       = 1'b1;
          edge_wa       = cur_q;
          edge_wd       = edge_rd_q;
          edge_wd.tri_b = cmd_q.tri_no;
          k_d           = k_q + 2'd1;
          state_d       = S_EDGE;
        end else if (link_rd_q == LinkNull) begin
          state_d = S_AP_START;
        end else begin
          cur_d   = link_rd_q[EdgeW-1:0];
          state_d = S_PR_CHK;
        end
      end
      // Appending writes the new slot, then links it at the list tail.
      S_AP_START: begin
        if (count_q == CountMax) begin
          status_d = StFull;
          k_d      = k_q + 2'd1;
          state_d  = S_EDGE;
        end else begin
          edge_we = 1'b1;
          link_we = 1'b1;
          state_d = S_AP_HWAIT;
        end
      end
      S_AP_HWAIT: begin
        if (head_rd_q == LinkNull) begin
          head_we = 1'b1;
          count_d = count_q + 1'b1;
          k_d     = k_q + 2'd1;
          state_d = S_EDGE;
        end else begin
          cur_d   = head_rd_q[EdgeW-1:0];
          state_d = S_AP_WALK;
        end
      end
      S_AP_WALK: begin
        state_d = S_AP_LWAIT;
      end
      S_AP_LWAIT: begin
        if (link_rd_q == LinkNull) begin
          link_we = 1'b1;
          link_wa = cur_q;
          link_wd = count_q;
          count_d = count_q + 1'b1;
          k_d     = k_q + 2'd1;
          state_d = S_EDGE;
        end else begin
          cur_d   = link_rd_q[EdgeW-1:0];
          state_d = S_AP_WALK;
        end
      end
      S_RESULT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          clr_d      = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o            = '{edge_rec: rd_edge_q, total: count_q, status: status_q};
  assign stat_o.init_busy = (state_q == S_SWEEP) && !clr_q;

endmodule

// ===== rtl/mel_resq.sv =====
// Two-entry result queue between the back part and the result ports.
module mel_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mel_pkg::res_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mel_pkg::res_t data_o
);
  import mel_pkg::*;

  res_t       q_mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = q_mem[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) q_mem[wr_q] <= data_i;
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/mesh_edge_list_builder.sv =====
// Top level of the mesh edge list builder: front, back and result queue.
//
//   Channel  Handshake          Payload
//   items    push / full        operation, three corners, triangle, edge number
//   results  pop / empty        edge fields, edge total, status
//
// After reset a pass sets every list head to null; full stays high meanwhile.
// A clear item runs the same pass. A read of an unstored index skips the memory
// read. A triangle walks one list per active edge; a second-pass edge that finds
// no partner walks a second list for its append.
// Both queues hold two entries, so each side may stall briefly without blocking
// the other.
module mesh_edge_list_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation_i,
  input  logic [9:0]  corner_zero_i,
  input  logic [9:0]  corner_one_i,
  input  logic [9:0]  corner_two_i,
  input  logic [10:0] triangle_number_i,
  input  logic [11:0] edge_number_i,
  output logic        empty,
  input  logic        pop,
  output logic [9:0]  edge_start_o,
  output logic [9:0]  edge_end_o,
  output logic [10:0] triangle_first_o,
  output logic [10:0] triangle_second_o,
  output logic [12:0] edge_total_o,
  output logic [1:0]  status_o
);
  import mel_pkg::*;

  bk_stat_t stat;
  logic     cmd_valid, cmd_pop, res_push, res_full;
  cmd_t     cmd;
  res_t     res_in, res_out;

  mel_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .operation_i, .corner_zero_i, .corner_one_i, .corner_two_i,
    .triangle_number_i, .edge_number_i,
    .stat_i(stat), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  mel_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .stat_o(stat), .res_push_o(res_push), .res_o(res_in), .res_full_i(res_full)
  );

  mel_resq u_resq (
    .clk_i, .rst_ni,
    .push_i(res_push), .data_i(res_in), .full_o(res_full),
    .pop_i(pop), .empty_o(empty), .data_o(res_out)
  );

  assign edge_start_o      = res_out.edge_rec.vtx_s;
  assign edge_end_o        = res_out.edge_rec.vtx_e;
  assign triangle_first_o  = res_out.edge_rec.tri_a;
  assign triangle_second_o = res_out.edge_rec.tri_b;
  assign edge_total_o      = res_out.total;
  assign status_o          = res_out.status;

  // The edge count never exceeds the table size.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> edge_total_o <= CountMax) else $error("edge total above table size");

  // A missed read carries zero edge fields.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == StMiss) |->
      (edge_start_o == '0 && edge_end_o == '0 && triangle_first_o == '0
       && triangle_second_o == '0)) else $error("missed read with edge data");

  // A full table is reported only once the table really is full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == StFull) |-> edge_total_o == CountMax)
    else $error("full status below table size");

endmodule

// ===== verif/mesh_edge_list_builder_tb.sv =====
// Testbench for the mesh edge list builder: random meshes, an edge table predictor and checks.
`timescale 1ns / 1ps

module mesh_edge_list_builder_tb;
  import mel_pkg::*;

  // Mirrors the edge table and holds the results still to come.
  class edge_table_scoreboard;
    int unsigned head_of[MaxVertices];
    int unsigned next_of[MaxEdges];
    edge_t       edges[MaxEdges];
    int unsigned edge_count;
    res_t        awaited[$];
    int          errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (head_of[v]) head_of[v] = LinkNull;
      edge_count = 0;
    endfunction

    function bit is_end(int unsigned node);
      return node == LinkNull || node >= edge_count;
    endfunction

    // Appends at the tail of the list of vertex lo; returns 0 when the table is full.
    function bit append(int unsigned lo, int unsigned s, int unsigned e, int unsigned tri_no);
      int unsigned slot;
      int unsigned node;
      if (edge_count >= MaxEdges) return 0;
      slot = edge_count;
      edges[slot] = '{vtx_s: VtxW'(s), vtx_e: VtxW'(e), tri_a: TriW'(tri_no),
                      tri_b: TriW'(tri_no)};
      next_of[slot] = LinkNull;
      node = head_of[lo];
      if (is_end(node)) begin
        head_of[lo] = slot;
      end else begin
        for (int unsigned n = 0; n < edge_count; n++) begin
          if (is_end(next_of[node])) break;
          node = next_of[node];
        end
        next_of[node] = slot;
      end
      edge_count = slot + 1;
      return 1;
    endfunction

    // Gives an unpaired edge from lo to hi this triangle as its second owner.
    function bit pair(int unsigned lo, int unsigned hi, int unsigned tri_no);
      int unsigned node;
      node = head_of[lo];
      for (int unsigned n = 0; n < edge_count; n++) begin
        if (is_end(node)) break;
        if (edges[node].vtx_e == hi && edges[node].tri_a == edges[node].tri_b) begin
          edges[node].tri_b = TriW'(tri_no);
          return 1;
        end
        node = next_of[node];
      end
      return 0;
    endfunction

    function void note_item(op_e op, logic [9:0] c0, logic [9:0] c1, logic [9:0] c2,
                            logic [10:0] tri_no, logic [11:0] idx);
      res_t r;
      int unsigned corner[3];
      int unsigned prev;
      r = '0;
      corner = '{c0, c1, c2};
      case (op)
        OP_CLEAR: wipe();
        OP_READ: begin
          if (idx < edge_count) r.edge_rec = edges[idx];
          else r.status = StMiss;
        end
        default: begin
          prev = corner[2];
          for (int k = 0; k < 3; k++) begin
            if (op == OP_PASS1) begin
              if (prev < corner[k] && !append(prev, prev, corner[k], tri_no))
                r.status = StFull;
            end else if (prev > corner[k] && !pair(corner[k], prev, tri_no)) begin
              if (!append(prev, prev, corner[k], tri_no)) r.status = StFull;
            end
            prev = corner[k];
          end
        end
      endcase
      r.total = CntW'(edge_count);
      awaited = {awaited, r};
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("result with no item waiting for it");
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("edge_start", want.edge_rec.vtx_s, got.edge_rec.vtx_s);
      compare("edge_end", want.edge_rec.vtx_e, got.edge_rec.vtx_e);
      compare("triangle_first", want.edge_rec.tri_a, got.edge_rec.tri_a);
      compare("triangle_second", want.edge_rec.tri_b, got.edge_rec.tri_b);
      compare("edge_total", want.total, got.total);
      compare("status", want.status, got.status);
    endfunction
  endclass

  localparam int StallLimit = 200000;

  logic        clk_i, rst_ni, push, full, empty, pop;
  logic [1:0]  operation_i;
  logic [9:0]  corner_zero_i, corner_one_i, corner_two_i;
  logic [10:0] triangle_number_i;
  logic [11:0] edge_number_i;
  logic [9:0]  edge_start_o, edge_end_o;
  logic [10:0] triangle_first_o, triangle_second_o;
  logic [12:0] edge_total_o;
  logic [1:0]  status_o;

  edge_table_scoreboard table_sb;
  int send_idle_pct, take_idle_pct, hold_left;

  mesh_edge_list_builder DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offers one item from a falling edge until it is taken.
  task automatic send_item(op_e op, int unsigned c0, int unsigned c1, int unsigned c2,
                           int unsigned tri_no, int unsigned idx);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    push <= 1'b1;
    operation_i <= op;
    corner_zero_i <= VtxW'(c0);
    corner_one_i <= VtxW'(c1);
    corner_two_i <= VtxW'(c2);
    triangle_number_i <= TriW'(tri_no);
    edge_number_i <= EdgeW'(idx);
    do @(posedge clk_i); while (full);
    table_sb.note_item(op, VtxW'(c0), VtxW'(c1), VtxW'(c2), TriW'(tri_no), EdgeW'(idx));
    @(negedge clk_i);
  endtask

  task automatic send_tri(op_e op, int c0, int c1, int c2, int tri_no);
    send_item(op, c0, c1, c2, tri_no, $urandom);
  endtask

  task automatic send_read(int idx);
    send_item(OP_READ, $urandom, $urandom, $urandom, $urandom, idx);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (table_sb.awaited.size() != 0) @(negedge clk_i);
  endtask

  // A small mesh fed in both passes after a clear, then read back, with some noise mixed in.
  task automatic send_mesh(int unsigned n_tri);
    int unsigned base;
    int unsigned tv[12][3];
    int unsigned tn[12];
    base = $urandom_range(0, 1008);
    for (int unsigned t = 0; t < n_tri; t++) begin
      tv[t] = '{base + $urandom_range(15), base + $urandom_range(15),
                base + $urandom_range(15)};
      tn[t] = $urandom_range(2047);
    end
    send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
    for (int unsigned t = 0; t < n_tri; t++)
      send_tri(OP_PASS1, tv[t][0], tv[t][1], tv[t][2], tn[t]);
    for (int unsigned t = 0; t < n_tri; t++) begin
      if ($urandom_range(9) == 0)
        send_item(op_e'($urandom_range(1, 3)), $urandom, $urandom, $urandom, $urandom,
                  $urandom);
      send_tri(OP_PASS2, tv[t][0], tv[t][1], tv[t][2], tn[t]);
    end
    repeat ($urandom_range(2, 8)) send_read($urandom_range(0, 3 * n_tri));
  endtask

  // Result side: pops at random, with long holds on request.
  initial begin
    pop = 1'b0;
    hold_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= take_idle_pct);
      end
      @(posedge clk_i);
      if (pop && !empty)
        table_sb.check_result('{edge_rec: '{edge_start_o, edge_end_o, triangle_first_o,
                                            triangle_second_o},
                                total: edge_total_o, status: status_o});
    end
  end

  // Ends the run when nothing moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned a;
    table_sb = new();
    send_idle_pct = 0;
    take_idle_pct = 0;
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = OP_CLEAR;
    corner_zero_i = '0;
    corner_one_i = '0;
    corner_two_i = '0;
    triangle_number_i = '0;
    edge_number_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, degenerate edges, boundary and shared edges, misses.
    send_read(0);
    send_tri(OP_PASS1, 0, 1, 1023, 2047);
    send_tri(OP_PASS1, 1, 0, 2, 0);
    send_tri(OP_PASS1, 5, 5, 5, 3);
    send_tri(OP_PASS1, 7, 7, 9, 4);
    send_tri(OP_PASS2, 0, 1, 1023, 2047);
    send_tri(OP_PASS2, 1, 0, 2, 0);
    send_tri(OP_PASS2, 1023, 1022, 0, 1);
    send_tri(OP_PASS2, 9, 7, 7, 4);
    for (int i = 0; i < 8; i++) send_read(i);
    send_read(4095);
    send_item(OP_CLEAR, '1, '1, '1, '1, '1);
    send_read(0);
    send_tri(OP_PASS2, 1023, 512, 0, 1024);
    send_read(0);

    // Three idling regimes, each with one pressure event.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 85 : 0;
      take_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 27 : 0;
      repeat (7) send_mesh($urandom_range(3, 12));
      hold_left = 300;
      repeat (12) send_read($urandom);
      repeat (3) send_mesh($urandom_range(3, 12));
      drain();
      repeat (8) send_item(op_e'($urandom_range(3)), $urandom, $urandom, $urandom,
                           $urandom, $urandom);
    end

    // Load the table with spread-out triangles, then pair against the long lists.
    send_idle_pct = 5;
    take_idle_pct = 5;
    send_item(OP_CLEAR, '0, '0, '0, '0, '0);
    for (int t = 0; t < 60; t++) begin
      a = $urandom_range(0, 1021);
      send_tri(OP_PASS1, a, $urandom_range(a + 1, 1022), 1023 - $urandom_range(0, 0), t);
      if (t % 20 == 0) send_read($urandom);
    end
    send_tri(OP_PASS2, 1000, 3, 500, 7);
    send_tri(OP_PASS2, 1023, 1, 2, 2047);
    send_read(4095);
    send_read(4094);
    repeat (10) send_read($urandom);
    send_item(OP_CLEAR, '0, '0, '0, '0, '0);
    send_read(0);

    drain();
    repeat (100) @(negedge clk_i);
    if (table_sb.errors == 0 && table_sb.awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mel_pkg.sv
rtl/mel_front.sv
rtl/mel_back.sv
rtl/mel_resq.sv
rtl/mesh_edge_list_builder.sv
verif/mesh_edge_list_builder_tb.sv
